// File: rtl/btkn_pkg.sv
// Shared types and constants for the bounded top-k nearest list.
package btkn_pkg;

  localparam int unsigned LIMIT_W = 3;

  // Power-up keep limit.
  localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RESET = 3'd3;

  // Item commands.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // take the input transaction and update the list
  } btkn_cmd_t;

endpackage

// File: rtl/btkn_if.sv
// Valid/ready channel interfaces for the list's input and result transactions.
interface btkn_in_if #(
  parameter int KEY_BITS = 25,
  parameter int ID_BITS  = 16
);
  logic                valid;
  logic                ready;
  logic                command;
  logic [KEY_BITS-1:0] distance_key;
  logic [ID_BITS-1:0]  entry_id;

  modport source (output valid, command, distance_key, entry_id, input ready);
  modport sink   (input valid, command, distance_key, entry_id, output ready);
endinterface

interface btkn_out_if #(
  parameter int KEY_BITS = 25,
  parameter int ID_BITS  = 16,
  parameter int CNT_W    = 3
);
  logic                valid;
  logic                ready;
  logic                accepted;
  logic                dropped_valid;
  logic [ID_BITS-1:0]  dropped_id;
  logic [KEY_BITS-1:0] dropped_key;
  logic [CNT_W-1:0]    entry_count;
  logic                best_valid;
  logic [ID_BITS-1:0]  best_id;
  logic [KEY_BITS-1:0] best_key;

  modport source (output valid, accepted, dropped_valid, dropped_id, dropped_key,
                  entry_count, best_valid, best_id, best_key, input ready);
  modport sink   (input valid, accepted, dropped_valid, dropped_id, dropped_key,
                  entry_count, best_valid, best_id, best_key, output ready);
endinterface

// File: rtl/btkn_ctrl.sv
// Handshake controller: tracks the result register and issues load commands.
module btkn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output btkn_pkg::btkn_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;  // result register empty
  localparam logic ST_HOLD = 1'b1;  // result waiting for the sink

  logic state_r;
  logic state_nxt;

  assign in_ready  = (state_r == ST_IDLE) || out_ready;
  assign out_valid = (state_r == ST_HOLD);
  assign cmd.load  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready && !in_valid) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // never overwrite a result the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && out_valid && !out_ready))
    else $error("result overwritten while stalled");

  // a load always leaves a result pending
  a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid)
    else $error("load without result");

  // a stalled result stays offered
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

// File: rtl/btkn_dpath.sv
// Datapath: sorted slot registers, parallel compare/shift, result register.
module btkn_dpath #(
  parameter int MAX_KEEP = 4,
  parameter int KEY_BITS = 25,
  parameter int ID_BITS  = 16,
  parameter int CNT_W    = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  btkn_pkg::btkn_cmd_t              cmd,
  input  logic                             in_command,
  input  logic [KEY_BITS-1:0]              in_key,
  input  logic [ID_BITS-1:0]               in_id,
  input  logic                             cfg_wr_en,
  input  logic [btkn_pkg::LIMIT_W-1:0]     cfg_wr_data,
  output logic                             out_accepted,
  output logic                             out_dropped_valid,
  output logic [ID_BITS-1:0]               out_dropped_id,
  output logic [KEY_BITS-1:0]              out_dropped_key,
  output logic [CNT_W-1:0]                 out_entry_count,
  output logic                             out_best_valid,
  output logic [ID_BITS-1:0]               out_best_id,
  output logic [KEY_BITS-1:0]              out_best_key
);

  localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  logic [KEY_BITS-1:0]          keys_r [MAX_KEEP];
  logic [ID_BITS-1:0]           ids_r  [MAX_KEEP];
  logic [KEY_BITS-1:0]          keys_nxt [MAX_KEEP];
  logic [ID_BITS-1:0]           ids_nxt  [MAX_KEEP];
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [btkn_pkg::LIMIT_W-1:0] limit_r;

  logic [CNT_W-1:0]    lim;
  logic [CNT_W-1:0]    last_cnt;
  logic [IDX_W-1:0]    last_idx;
  logic [MAX_KEEP-1:0] lt;
  logic                any_lt, full, is_insert, accept;
  logic                drop_v;
  logic [ID_BITS-1:0]  drop_id;
  logic [KEY_BITS-1:0] drop_key;

  // effective limit: zero acts as one, saturate at storage depth
  always_comb begin
    if (limit_r == '0) begin
      lim = CNT_W'(1);
    end else if (32'(limit_r) > MAX_KEEP) begin
      lim = CNT_W'(MAX_KEEP);
    end else begin
      lim = CNT_W'(limit_r);
    end
  end

  assign last_cnt  = count_r - CNT_W'(1);
  assign last_idx  = last_cnt[IDX_W-1:0];
  assign full      = (count_r >= lim);
  assign is_insert = (in_command == btkn_pkg::CMD_INSERT);

  always_comb begin
    for (int j = 0; j < MAX_KEEP; j++) begin
      lt[j] = (CNT_W'(j) < count_r) && (in_key < keys_r[j]);
    end
  end
  assign any_lt = |lt;
  assign accept = is_insert && (any_lt || !full);

  // slot update: keys are sorted, so lt is a run of ones at the tail
  always_comb begin
    for (int j = 0; j < MAX_KEEP; j++) begin
      keys_nxt[j] = keys_r[j];
      ids_nxt[j]  = ids_r[j];
      if (is_insert) begin
        if (j > 0 && lt[j-1]) begin
          keys_nxt[j] = keys_r[j-1];
          ids_nxt[j]  = ids_r[j-1];
        end else if (lt[j]) begin
          keys_nxt[j] = in_key;
          ids_nxt[j]  = in_id;
        end else if (CNT_W'(j) == count_r && !any_lt && !full) begin
          keys_nxt[j] = in_key;
          ids_nxt[j]  = in_id;
        end
      end
    end
  end

  always_comb begin
    drop_v   = 1'b0;
    drop_id  = '0;
    drop_key = '0;
    if (is_insert && full) begin
      drop_v = 1'b1;
      if (any_lt) begin
        drop_id  = ids_r[last_idx];
        drop_key = keys_r[last_idx];
      end else begin
        drop_id  = in_id;
        drop_key = in_key;
      end
    end
  end

  always_comb begin
    if (!is_insert) begin
      count_nxt = '0;
    end else if (accept && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= btkn_pkg::KEEP_LIMIT_RESET;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (cmd.load)  count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < MAX_KEEP; j++) begin
        keys_r[j] <= keys_nxt[j];
        ids_r[j]  <= ids_nxt[j];
      end
      out_accepted      <= accept;
      out_dropped_valid <= drop_v;
      out_dropped_id    <= drop_id;
      out_dropped_key   <= drop_key;
      out_entry_count   <= count_nxt;
      out_best_valid    <= (count_nxt != '0);
      out_best_id       <= (count_nxt != '0) ? ids_nxt[0]  : '0;
      out_best_key      <= (count_nxt != '0) ? keys_nxt[0] : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_KEEP)
    else $error("entry count beyond storage");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !is_insert) |=> (count_r == '0))
    else $error("clear left entries");

  a_accept_xor_drop_new: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && is_insert) |-> (accept || drop_v))
    else $error("insert neither kept nor refused");

  for (genvar g = 1; g < MAX_KEEP; g++) begin : g_sorted
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (CNT_W'(g) < count_r) |-> (keys_r[g-1] <= keys_r[g]))
      else $error("held keys out of order");
  end

endmodule

// File: rtl/bounded_top_k_nearest_list.sv
// Top level of the bounded top-k nearest list.
//
// Keeps up to keep_limit (1..MAX_KEEP) entries sorted by ascending distance key.
// in_ch carries one transaction per item: command (insert or clear), the
// distance key and the entry id. Equal keys stay in arrival order; a full list
// evicts its last entry, or refuses the new one when it would land last.
// out_ch returns exactly one result transaction per input transaction: accepted
// flag, evicted/refused entry, count after the step and the current best entry.
// Latency: the result is valid the cycle after the input transaction.
// Throughput: one item per cycle while the sink takes each result, set by the
// parallel compare and shift across all slots; the result register lets a new
// transaction enter in the same cycle the sink takes the previous result.
// Stall: while a result waits and out_ch.ready is low, in_ch.ready is low.
// cfg_wr_en/cfg_wr_data write keep_limit; write it only while idle.
// Reset (synchronous, rst_n low): list empty, no result pending, keep_limit 3.
module bounded_top_k_nearest_list #(
  parameter int MAX_KEEP = 4,
  parameter int KEY_BITS = 25,
  parameter int ID_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  btkn_in_if.sink                      in_ch,
  btkn_out_if.source                   out_ch,
  input  logic                         cfg_wr_en,
  input  logic [btkn_pkg::LIMIT_W-1:0] cfg_wr_data
);

  // count width covers 0..MAX_KEEP; out_ch is built with the same value
  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  btkn_pkg::btkn_cmd_t cmd;

  // handshake side: in_ready / out_valid and the load strobe
  btkn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // slots, limit register and the registered result payload
  btkn_dpath #(
    .MAX_KEEP (MAX_KEEP),
    .KEY_BITS (KEY_BITS),
    .ID_BITS  (ID_BITS),
    .CNT_W    (CNT_W)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_command        (in_ch.command),
    .in_key            (in_ch.distance_key),
    .in_id             (in_ch.entry_id),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_accepted      (out_ch.accepted),
    .out_dropped_valid (out_ch.dropped_valid),
    .out_dropped_id    (out_ch.dropped_id),
    .out_dropped_key   (out_ch.dropped_key),
    .out_entry_count   (out_ch.entry_count),
    .out_best_valid    (out_ch.best_valid),
    .out_best_id       (out_ch.best_id),
    .out_best_key      (out_ch.best_key)
  );

endmodule

// File: tb/bounded_top_k_nearest_list_checker.sv
// Checker for the top-k nearest list: tracks the list and compares every result transaction.
`timescale 1ns / 100ps
module bounded_top_k_nearest_list_checker #(
  parameter int MAX_KEEP = 4,
  parameter int KEY_BITS = 25,
  parameter int ID_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  btkn_in_if                           in_ch,
  btkn_out_if                          out_ch,
  input  logic                         cfg_wr_en,
  input  logic [btkn_pkg::LIMIT_W-1:0] cfg_wr_data,
  output int                           fail_count,
  output int                           pending_count
);

  typedef struct packed {
    logic                accepted;
    logic                dropped_valid;
    logic [ID_BITS-1:0]  dropped_id;
    logic [KEY_BITS-1:0] dropped_key;
    logic [2:0]          entry_count;
    logic                best_valid;
    logic [ID_BITS-1:0]  best_id;
    logic [KEY_BITS-1:0] best_key;
  } list_result_t;

  // Shadow copy of the list, slots in ascending key order.
  logic [KEY_BITS-1:0]          slot_key [MAX_KEEP];
  logic [ID_BITS-1:0]           slot_id  [MAX_KEEP];
  int                           slot_count = 0;
  logic [btkn_pkg::LIMIT_W-1:0] keep_limit = btkn_pkg::KEEP_LIMIT_RESET;

  list_result_t expected_q [$];
  int           mismatches = 0;

  // Applies one insert or clear to the shadow list and returns the result it yields.
  function automatic list_result_t advance_nearest_list(logic cmd, logic [KEY_BITS-1:0] key,
                                                        logic [ID_BITS-1:0] id);
    list_result_t r;
    int           lim;
    int           n;
    int           pos;
    bit           full;
    r   = '0;
    lim = int'(keep_limit);
    if (lim < 1) lim = 1;
    if (lim > MAX_KEEP) lim = MAX_KEEP;
    n = slot_count;
    if (cmd == btkn_pkg::CMD_CLEAR) begin
      n = 0;
    end else if (n == 0) begin
      slot_key[0] = key;
      slot_id[0]  = id;
      n = 1;
      r.accepted = 1'b1;
    end else begin
      // first slot with a strictly larger key; ties land behind
      pos = n;
      for (int i = n - 1; i >= 0; i--) begin
        if (key < slot_key[i]) pos = i;
      end
      if (pos < n) begin
        full = (n >= lim);
        if (full) begin
          r.dropped_valid = 1'b1;
          r.dropped_id    = slot_id[n-1];
          r.dropped_key   = slot_key[n-1];
        end
        for (int i = full ? n - 1 : n; i > pos; i--) begin
          slot_key[i] = slot_key[i-1];
          slot_id[i]  = slot_id[i-1];
        end
        slot_key[pos] = key;
        slot_id[pos]  = id;
        if (!full) n++;
        r.accepted = 1'b1;
      end else if (n >= lim) begin
        r.dropped_valid = 1'b1;
        r.dropped_id    = id;
        r.dropped_key   = key;
      end else begin
        slot_key[n] = key;
        slot_id[n]  = id;
        n++;
        r.accepted = 1'b1;
      end
    end
    slot_count    = n;
    r.entry_count = 3'(n);
    if (n > 0) begin
      r.best_valid = 1'b1;
      r.best_id    = slot_id[0];
      r.best_key   = slot_key[0];
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Outputs and inputs are sampled before the edge's updates land.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      slot_count = 0;
      keep_limit = btkn_pkg::KEEP_LIMIT_RESET;
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t result transaction with nothing outstanding", $time);
        end else begin
          want = expected_q.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(out_ch.accepted));
          check_field("dropped_valid", 32'(want.dropped_valid), 32'(out_ch.dropped_valid));
          check_field("dropped_id", 32'(want.dropped_id), 32'(out_ch.dropped_id));
          check_field("dropped_key", 32'(want.dropped_key), 32'(out_ch.dropped_key));
          check_field("entry_count", 32'(want.entry_count), 32'(out_ch.entry_count));
          check_field("best_valid", 32'(want.best_valid), 32'(out_ch.best_valid));
          check_field("best_id", 32'(want.best_id), 32'(out_ch.best_id));
          check_field("best_key", 32'(want.best_key), 32'(out_ch.best_key));
        end
      end
      if (cfg_wr_en) keep_limit = cfg_wr_data;
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(advance_nearest_list(in_ch.command, in_ch.distance_key,
                                                  in_ch.entry_id));
    end
    fail_count    <= mismatches;
    pending_count <= expected_q.size();
  end

endmodule

// File: tb/bounded_top_k_nearest_list_test.sv
// Top of the testbench: clock, reset, stimulus and verdict for the top-k nearest list.
`timescale 1ns / 100ps
module bounded_top_k_nearest_list_test;

  localparam int KEY_W = 25;
  localparam int ID_W  = 16;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [ID_W-1:0]  ID_MAX  = '1;

  localparam int ITEMS_PER_PHASE = 150;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [btkn_pkg::LIMIT_W-1:0] cfg_wr_data;

  // Chance, in percent, that the sender idles / the receiver stalls in a cycle.
  int send_idle_pct;
  int recv_stall_pct;

  int fail_count;
  int pending_count;

  // Per-phase plan: keep_limit values (0, 5 and 7 probe the clamping) and
  // idle mixes cycling through none, sender only, receiver only, both.
  logic [btkn_pkg::LIMIT_W-1:0] limit_plan [8] =
    '{3'd2, 3'd4, 3'd1, 3'd0, 3'd3, 3'd7, 3'd4, 3'd5};
  int                           send_plan  [4] = '{0, 77, 0, 19};
  int                           recv_plan  [4] = '{0, 0, 77, 19};

  btkn_in_if  in_ch ();
  btkn_out_if out_ch ();

  bounded_top_k_nearest_list dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Watches both channels and the config port; owns all result checking.
  bounded_top_k_nearest_list_checker result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one transaction. Idle cycles come first, with valid low; once
  // valid is up it stays up until the handshake. Back-to-back items keep
  // valid high, so valid gets a single update per edge.
  task automatic send_item(logic cmd, logic [KEY_W-1:0] key, logic [ID_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.distance_key <= key;
    in_ch.entry_id     <= id;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // keep_limit may only change while idle: drain all outstanding results, then write.
  task automatic set_limit(logic [btkn_pkg::LIMIT_W-1:0] lim);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly inserts so the list stays full; keys bunch up in small ranges
  // to get plenty of ties and reorders, plus full-range and extreme keys.
  task automatic send_random_item();
    logic             cmd;
    logic [KEY_W-1:0] key;
    cmd = ($urandom_range(99) < 6) ? btkn_pkg::CMD_CLEAR : btkn_pkg::CMD_INSERT;
    case ($urandom_range(3))
      0:       key = KEY_W'($urandom);
      1:       key = KEY_W'($urandom_range(15));
      2:       key = $urandom_range(1) ? KEY_MAX : '0;
      default: key = KEY_W'($urandom_range(2000));
    endcase
    send_item(cmd, key, ID_W'($urandom));
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.command      = btkn_pkg::CMD_INSERT;
    in_ch.distance_key = '0;
    in_ch.entry_id     = '0;
    out_ch.ready       = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    rst_n              = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first under the reset limit of three.
    send_item(btkn_pkg::CMD_INSERT, KEY_MAX, ID_MAX);    // empty list always takes it
    send_item(btkn_pkg::CMD_INSERT, '0, '0);             // goes to the front
    send_item(btkn_pkg::CMD_INSERT, '0, 16'd1);          // tie stays behind the older entry
    send_item(btkn_pkg::CMD_INSERT, KEY_MAX, 16'h1234);  // full, would land last: refused
    send_item(btkn_pkg::CMD_INSERT, 25'd5, 16'h00a5);    // full: evicts the largest
    send_item(btkn_pkg::CMD_CLEAR, KEY_MAX, ID_MAX);
    send_item(btkn_pkg::CMD_CLEAR, '0, '0);              // clear on an empty list

    set_limit(3'd1);
    send_item(btkn_pkg::CMD_INSERT, 25'd100, 16'd1);
    send_item(btkn_pkg::CMD_INSERT, 25'd50, 16'd2);      // evicts the only entry
    send_item(btkn_pkg::CMD_INSERT, 25'd50, 16'd3);      // tie on a full list: refused

    set_limit(3'd4);
    send_item(btkn_pkg::CMD_INSERT, 25'd40, 16'd4);
    send_item(btkn_pkg::CMD_INSERT, 25'd30, 16'd5);
    send_item(btkn_pkg::CMD_INSERT, 25'd20, 16'd6);
    send_item(btkn_pkg::CMD_INSERT, 25'd10, 16'd7);      // list of four full: evicts 50

    // Limit of zero acts as one, and the four held entries are not trimmed.
    set_limit(3'd0);
    send_item(btkn_pkg::CMD_INSERT, 25'd5, 16'd8);
    send_item(btkn_pkg::CMD_INSERT, KEY_MAX, 16'd9);

    // Limit above storage saturates at four.
    set_limit(3'd7);
    send_item(btkn_pkg::CMD_INSERT, '0, 16'd10);
    send_item(btkn_pkg::CMD_CLEAR, '0, '0);

    // Random part. The list is not cleared between phases, so a lower limit
    // often meets a list holding more entries than it allows.
    for (int ph = 0; ph < 8; ph++) begin
      set_limit(limit_plan[ph]);
      send_idle_pct  = send_plan[ph % 4];
      recv_stall_pct = recv_plan[ph % 4];
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    // Drain, then keep the clock running to catch any stray result transaction.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
